// ----- hw/rtl/psc_pkg.sv -----
// psc_pkg: shared types and constants of the prime sieve chain
// used by psc_cell and prime_sieve_chain_core, no dependencies
package psc_pkg;

    localparam int NUM_CELLS_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int DATA_W          = 16;

    // one bit of a candidate travelling down the chain
    typedef struct packed {
        logic valid;
        logic dbit;   // candidate bit, msb first
        logic first;  // first bit of a candidate, restarts the remainder
        logic last;   // last bit, hit is final here
        logic hit;    // some filled cell so far divides the candidate
    } t_tok;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_WAIT,
        S_RES
    } t_state;

endpackage

// ----- hw/rtl/psc_cell.sv -----
// psc_cell: one sieve cell, holds a prime and runs a bit-serial remainder
// on the candidate bits streaming past; depends on psc_pkg
module psc_cell #(
    parameter int CW = psc_pkg::VALUE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psc_pkg::t_tok   i_tok,
    output psc_pkg::t_tok   o_tok,
    input  logic            i_prev_filled,
    output logic            o_filled,
    input  logic            i_clear,
    input  logic            i_ins,
    input  logic [CW-1:0]   i_ins_value
);
    import psc_pkg::*;

    logic          r_filled;
    logic [CW-1:0] r_prime;
    logic [CW-1:0] r_rem;
    t_tok          r_tok;

    logic [CW:0]   shifted;
    logic [CW:0]   reduced;
    logic [CW-1:0] n_rem;
    t_tok          n_tok;

    always_comb begin
        shifted = {(i_tok.first ? {CW{1'b0}} : r_rem), i_tok.dbit};
        if (shifted >= {1'b0, r_prime}) begin
            reduced = shifted - {1'b0, r_prime};
        end else begin
            reduced = shifted;
        end
        n_rem = reduced[CW-1:0];
        n_tok = i_tok;
        if (i_tok.valid && i_tok.last) begin
            n_tok.hit = i_tok.hit | (r_filled & (n_rem == '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_clear) begin
                r_filled <= 1'b0;
            end else if (i_ins && i_prev_filled && !r_filled) begin
                r_filled <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_tok.valid) begin
            r_rem <= n_rem;
        end
        if (i_ins && i_prev_filled && !r_filled) begin
            r_prime <= i_ins_value;
        end
    end

    assign o_tok    = r_tok;
    assign o_filled = r_filled;

endmodule

// ----- hw/rtl/prime_sieve_chain_core.sv -----
// prime_sieve_chain_core: top level of the prime sieve chain
// instantiates a row of psc_cell, depends on psc_pkg
//
// usage:
//   slave channel: one candidate per transaction, tdata = value, tlast =
//   end_of_stream. the end marker answers with one done result (tlast high,
//   tdata zero) and empties every cell. candidates 0 and 1 are dropped.
//   master channel: tdata = prime_value, tuser = overflow, tlast = done_res.
//   a candidate that some held prime divides gives no transaction.
// processing:
//   a candidate's bits enter the chain msb first, one per cycle, and ripple
//   through NUM_CELLS cells, each cell registering the bit and doing one
//   restoring remainder step per bit. the next candidate is taken once the
//   previous one has left the chain.
//   the first empty cell takes a new prime; with all cells full the
//   candidate is reported with overflow and not stored.
// reset: cells empty, no result pending, master tvalid low.
// stall: a result waits in the output register while the next candidate
//   is already processed; a second result then waits until the first is
//   taken, and the slave side holds tready low meanwhile.
module prime_sieve_chain_core #(
    parameter int NUM_CELLS   = psc_pkg::NUM_CELLS_DEF,
    parameter int VALUE_WIDTH = psc_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [psc_pkg::DATA_W-1:0] i_s_axis_tdata,   // [15:0] value
    input  logic                       i_s_axis_tlast,   // end_of_stream
    // master side
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [psc_pkg::DATA_W-1:0] o_m_axis_tdata,   // [15:0] prime_value
    output logic                       o_m_axis_tuser,   // [0] overflow
    output logic                       o_m_axis_tlast    // done_res
);
    import psc_pkg::*;

    // candidate width: field is 16 bits, masked to VALUE_WIDTH
    localparam int CW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int IW = $clog2(CW);

    t_state r_state, n_state;

    logic [CW-1:0]     r_cand;
    logic [IW-1:0]     r_idx;
    // pending result, waiting for the output register
    logic [DATA_W-1:0] r_res_prime;
    logic              r_res_ovf;
    logic              r_res_done;
    // output register
    logic              r_m_valid;
    logic [DATA_W-1:0] r_m_data;
    logic              r_m_user;
    logic              r_m_last;

    t_tok              w_head_tok;
    t_tok              w_tok  [NUM_CELLS+1];
    logic              w_fill [NUM_CELLS+1];

    logic [CW-1:0]     w_cand;
    logic              s_accept;
    logic              out_free;
    logic              chain_done;
    logic              chain_hit;
    logic              sieve_full;
    logic              ins;
    logic              clr;
    logic              load_out;
    logic              take_res;

    assign w_cand     = i_s_axis_tdata[CW-1:0];
    assign s_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_m_valid || i_m_axis_tready;
    assign chain_done = w_tok[NUM_CELLS].valid && w_tok[NUM_CELLS].last;
    assign chain_hit  = w_tok[NUM_CELLS].hit;
    assign sieve_full = w_fill[NUM_CELLS];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (i_s_axis_tlast) begin
                        n_state = S_RES;
                    end else if (w_cand[CW-1:1] != '0) begin
                        n_state = S_FEED;
                    end
                end
            end
            S_FEED: begin
                if (r_idx == '0) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (chain_done) begin
                    n_state = chain_hit ? S_IDLE : S_RES;
                end
            end
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_head_tok      = '0;
        ins             = 1'b0;
        clr             = 1'b0;
        load_out        = 1'b0;
        take_res        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                clr             = i_s_axis_tvalid && i_s_axis_tlast;
            end
            S_FEED: begin
                w_head_tok.valid = 1'b1;
                w_head_tok.dbit  = r_cand[r_idx];
                w_head_tok.first = (r_idx == IW'(CW - 1));
                w_head_tok.last  = (r_idx == '0);
            end
            S_WAIT: begin
                take_res = chain_done && !chain_hit;
                ins      = take_res && !sieve_full;
            end
            S_RES: begin
                load_out = out_free;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // the chain of cells, filled flags ripple from cell 0
    assign w_tok[0]  = w_head_tok;
    assign w_fill[0] = 1'b1;
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        psc_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_tok         (w_tok[g]),
            .o_tok         (w_tok[g+1]),
            .i_prev_filled (w_fill[g]),
            .o_filled      (w_fill[g+1]),
            .i_clear       (clr),
            .i_ins         (ins),
            .i_ins_value   (r_cand)
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cand <= w_cand;
            r_idx  <= IW'(CW - 1);
        end else if (r_state == S_FEED) begin
            r_idx <= r_idx - 1'b1;
        end
        if (s_accept && i_s_axis_tlast) begin
            // done result answering the end marker
            r_res_prime <= '0;
            r_res_ovf   <= 1'b0;
            r_res_done  <= 1'b1;
        end else if (take_res) begin
            r_res_prime <= DATA_W'(r_cand);
            r_res_ovf   <= sieve_full;
            r_res_done  <= 1'b0;
        end
        if (load_out) begin
            r_m_data <= r_res_prime;
            r_m_user <= r_res_ovf;
            r_m_last <= r_res_done;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;
    assign o_m_axis_tlast  = r_m_last;

endmodule
